FILE: rtl/rnp_pkg.sv
package rnp_pkg;

  localparam logic [7:0] SymI = 8'h49;
  localparam logic [7:0] SymV = 8'h56;
  localparam logic [7:0] SymX = 8'h58;
  localparam logic [7:0] SymL = 8'h4c;
  localparam logic [7:0] SymC = 8'h43;
  localparam logic [7:0] SymD = 8'h44;
  localparam logic [7:0] SymM = 8'h4d;
  localparam logic [7:0] SymNone = 8'h00;

  localparam int unsigned NumPos = 4;
  localparam logic [2:0] PosThousands = 3'd0;
  localparam logic [2:0] PosHundreds  = 3'd1;
  localparam logic [2:0] PosTens      = 3'd2;
  localparam logic [2:0] PosUnits     = 3'd3;
  localparam logic [2:0] PosDone      = 3'd4;

  localparam logic [11:0] MaxValue = 12'd3999;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_CHAR   = 2'd1,
    ERR_REPEAT = 2'd2,
    ERR_PAIR   = 2'd3
  } err_e;

  function automatic logic [7:0] one_sym(logic [2:0] pos);
    case (pos)
      PosThousands: return SymM;
      PosHundreds:  return SymC;
      PosTens:      return SymX;
      PosUnits:     return SymI;
      default:      return SymNone;
    endcase
  endfunction

  // thousands has no five or ten form
  function automatic logic [7:0] five_sym(logic [2:0] pos);
    case (pos)
      PosHundreds: return SymD;
      PosTens:     return SymL;
      PosUnits:    return SymV;
      default:     return SymNone;
    endcase
  endfunction

  function automatic logic [7:0] ten_sym(logic [2:0] pos);
    case (pos)
      PosHundreds: return SymM;
      PosTens:     return SymC;
      PosUnits:    return SymX;
      default:     return SymNone;
    endcase
  endfunction

  function automatic logic [11:0] unit_val(logic [2:0] pos);
    case (pos)
      PosThousands: return 12'd1000;
      PosHundreds:  return 12'd100;
      PosTens:      return 12'd10;
      PosUnits:     return 12'd1;
      default:      return 12'd0;
    endcase
  endfunction

endpackage

FILE: rtl/roman_numeral_parser.sv
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+--------------------------
// input    | in        | in_valid_i / in_stall_o   | symbol_i, last_symbol_i
// result   | out       | out_valid_o / out_stall_i | value_o, error_code_o
//
// one character per cycle unless a stalled result holds a last character;
// a request waits in the input register, then updates the digit state in a
// single step; a numeral's last character then writes the result register
// rst_ni clears the digit state and both valid flags; payload is not reset
// a stalled result holds only a last character in the input register;
// other characters keep flowing while the result waits
module roman_numeral_parser
  import rnp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  symbol_i,
  input  logic        last_symbol_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] value_o,
  output logic [1:0]  error_code_o
);

  typedef enum logic [1:0] {
    PH_NONE,
    PH_ONES,
    PH_FIVE
  } phase_e;

  typedef struct packed {
    logic        hit;
    err_e        err;
    logic [2:0]  pos;
    phase_e      ph;
    logic [1:0]  cnt;
    logic [11:0] add;
  } step_t;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_sym_q;
  logic       s1_last_q;

  // digit state
  logic [2:0]  pos_q, pos_d;
  phase_e      ph_q, ph_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [11:0] run_q, run_d;
  err_e        err_q, err_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [11:0] value_q;
  err_e        code_q;

  logic  s1_adv, s1_fire, in_acc;
  step_t lane [NumPos];
  step_t res;
  err_e  eff_err;
  logic [11:0] new_run;

  assign s1_adv     = !s1_last_q || !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && s1_adv;

  // one lane per digit position; the lowest open position that takes the
  // character wins, later positions are tried as if freshly opened
  always_comb begin
    logic [2:0]  qp;
    logic        is_one, is_five, is_ten;
    logic [11:0] u;
    for (int q = 0; q < NumPos; q++) begin
      qp      = 3'(q);
      u       = unit_val(qp);
      is_one  = s1_sym_q == one_sym(qp);
      is_five = (qp != PosThousands) && (s1_sym_q == five_sym(qp));
      is_ten  = (qp != PosThousands) && (s1_sym_q == ten_sym(qp));
      lane[q] = '{hit: 1'b0, err: ERR_NONE, pos: qp, ph: PH_NONE, cnt: 2'd0,
                  add: 12'd0};
      if (pos_q == qp && ph_q == PH_ONES) begin
        if (is_one) begin
          lane[q].hit = 1'b1;
          lane[q].ph  = PH_ONES;
          if (cnt_q == 2'd3) begin
            lane[q].err = ERR_REPEAT;
          end else begin
            lane[q].cnt = cnt_q + 2'd1;
            lane[q].add = u;
          end
        end else if (is_five || is_ten) begin
          lane[q].hit = 1'b1;
          if (cnt_q != 2'd1) begin
            lane[q].err = ERR_PAIR;
          end else begin
            // subtractive pair closes this position
            lane[q].pos = qp + 3'd1;
            lane[q].add = is_five ? 12'(u * 12'd3) : 12'(u * 12'd8);
          end
        end
      end else if (pos_q == qp && ph_q == PH_FIVE) begin
        if (is_one) begin
          lane[q].hit = 1'b1;
          lane[q].ph  = PH_FIVE;
          if (cnt_q == 2'd3) begin
            lane[q].err = ERR_REPEAT;
          end else begin
            lane[q].cnt = cnt_q + 2'd1;
            lane[q].add = u;
          end
        end
      end else if (pos_q <= qp) begin
        if (is_one) begin
          lane[q].hit = 1'b1;
          lane[q].ph  = PH_ONES;
          lane[q].cnt = 2'd1;
          lane[q].add = u;
        end else if (is_five) begin
          lane[q].hit = 1'b1;
          lane[q].ph  = PH_FIVE;
          lane[q].add = 12'(u * 12'd5);
        end
      end
    end
  end

  always_comb begin
    res = '{hit: 1'b0, err: ERR_CHAR, pos: PosDone, ph: PH_NONE, cnt: 2'd0,
            add: 12'd0};
    for (int q = NumPos - 1; q >= 0; q--) begin
      if (lane[q].hit) begin
        res = lane[q];
      end
    end
  end

  assign eff_err = (err_q != ERR_NONE) ? err_q : res.err;
  assign new_run = run_q + res.add;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    pos_d = pos_q;
    ph_d  = ph_q;
    cnt_d = cnt_q;
    run_d = run_q;
    err_d = err_q;
    if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_fire) begin
      if (s1_last_q) begin
        out_valid_d = 1'b1;
        pos_d = PosThousands;
        ph_d  = PH_NONE;
        cnt_d = 2'd0;
        run_d = 12'd0;
        err_d = ERR_NONE;
      end else if (eff_err != ERR_NONE) begin
        err_d = eff_err;
      end else begin
        pos_d = res.pos;
        ph_d  = res.ph;
        cnt_d = res.cnt;
        run_d = new_run;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q <= PosThousands;
      ph_q  <= PH_NONE;
      cnt_q <= 2'd0;
      run_q <= 12'd0;
      err_q <= ERR_NONE;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      pos_q <= pos_d;
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      run_q <= run_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sym_q  <= symbol_i;
      s1_last_q <= last_symbol_i;
    end
    if (s1_fire && s1_last_q) begin
      value_q <= (eff_err == ERR_NONE) ? new_run : 12'd0;
      code_q  <= eff_err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign error_code_o = code_q;

endmodule

FILE: rtl/rnp_checker.sv
module rnp_checker
  import rnp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] value_o,
  input logic [1:0]  error_code_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(value_o) && $stable(error_code_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> value_o == 12'd0)
    else $error("failed numeral carries a value");

  // a good numeral has at least one symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ERR_NONE |-> value_o != 12'd0)
    else $error("good numeral with zero value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> value_o <= MaxValue)
    else $error("value above range");

endmodule

bind roman_numeral_parser rnp_checker u_rnp_checker (.*);
